### design/evid_pkg.sv
// Shared types and constants for the event number allocator.
// Holds the controller/datapath command and status types; depends on nothing.
`default_nettype none
package evid_pkg;

    // default sizing
    localparam int BIN_COUNT_DEF = 256;
    localparam int ID_SPACE_DEF  = 8192;

    // configuration register reset values
    localparam logic [15:0] FIRST_RST = 16'h2000;
    localparam logic [15:0] LAST_RST  = 16'h4000;

    // fixed field widths
    localparam int NUM_W  = 16;
    localparam int TAG_W  = 32;
    localparam int PEAK_W = 14;

    // configuration register indexes
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_LAST  = 1'b1;

    // request modes
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_FREE     = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FAIL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WALK_WAIT,
        ST_WALK_CHK,
        ST_INC_WAIT,
        ST_INC,
        ST_ADV,
        ST_SM_WAIT,
        ST_SM_CHK,
        ST_P1_WAIT,
        ST_P1_CHK,
        ST_P2_WAIT,
        ST_P2_CHK,
        ST_TK_WAIT,
        ST_TK_CHK,
        ST_MOD,
        ST_DEC_WAIT,
        ST_DEC,
        ST_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_INIT,
        OP_CLEAR,
        OP_LOAD,
        OP_SET_RANGE,
        OP_ALLOC_START,
        OP_OFF_STEP,
        OP_SET_NONE,
        OP_GRANT,
        OP_INC,
        OP_ADV_START,
        OP_SCAN_STEP,
        OP_SET_NEXT,
        OP_P2_START,
        OP_P2_ACC,
        OP_P2_END,
        OP_SET_OFF,
        OP_DISPATCH,
        OP_FREE,
        OP_MOD_STEP,
        OP_MOD_DONE,
        OP_DEC,
        OP_EMIT
    } t_dp_op;

    // datapath flags seen by the controller
    typedef struct packed {
        logic [1:0] mode;
        logic       none;
        logic       in_range;
        logic       off_lt_span;
        logic       taken;
        logic       short_span;
        logic       scan_lt_span;
        logic       scan_end;
        logic       depth_zero;
        logic       depth_le_min;
        logic       rem_ge_bc;
        logic       clr_done;
    } t_dp_stat;

endpackage
`default_nettype wire

### design/evid_dp.sv
// Datapath of the event number allocator: config registers, taken map,
// handler store, per-bin depth memory, pointer and counters. Uses evid_pkg.
`default_nettype none
module evid_dp #(
    parameter int BIN_COUNT = evid_pkg::BIN_COUNT_DEF,
    parameter int ID_SPACE  = evid_pkg::ID_SPACE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire evid_pkg::t_dp_op            i_op,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [15:0]                 i_cfg_wdata,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [evid_pkg::NUM_W-1:0]  i_number,
    input  wire logic [evid_pkg::TAG_W-1:0]  i_cb,
    input  wire logic [evid_pkg::TAG_W-1:0]  i_arg,
    output evid_pkg::t_dp_stat               o_stat,
    output logic [1:0]                       o_status,
    output logic [evid_pkg::NUM_W-1:0]       o_granted,
    output logic [evid_pkg::TAG_W-1:0]       o_cb,
    output logic [evid_pkg::TAG_W-1:0]       o_arg,
    output logic [evid_pkg::PEAK_W-1:0]      o_peak
);

    localparam int OW      = $clog2(ID_SPACE);
    localparam int BW      = $clog2(BIN_COUNT);
    localparam int OFW     = $clog2(ID_SPACE + BIN_COUNT);
    localparam int DAW     = $clog2(BIN_COUNT + 1);
    localparam int SW      = $clog2(ID_SPACE + 1);
    localparam int CHAIN   = (ID_SPACE + BIN_COUNT - 1) / BIN_COUNT;
    localparam int DW      = $clog2(CHAIN + 1);
    localparam int CLR_LEN = (ID_SPACE > BIN_COUNT) ? ID_SPACE : BIN_COUNT;

    // memories
    logic                              r_taken_mem [ID_SPACE];
    logic [2*evid_pkg::TAG_W-1:0]      r_hdl_mem   [ID_SPACE];
    logic [DW-1:0]                     r_depth_mem [BIN_COUNT];
    logic                              r_taken_q;
    logic [2*evid_pkg::TAG_W-1:0]      r_hdl_q;
    logic [DW-1:0]                     r_depth_q;

    // control state
    logic [15:0]    r_first;
    logic [15:0]    r_last;
    logic [OFW-1:0] r_off;
    logic [DAW-1:0] r_daddr;
    logic [BW-1:0]  r_bin;
    logic [BW-1:0]  r_next;
    logic           r_none;
    logic [DW-1:0]  r_min;
    logic [SW-1:0]  r_live;
    logic [SW-1:0]  r_peak;
    logic           r_found;
    logic [BW-1:0]  r_best;
    logic [DW-1:0]  r_best_d;

    // latched request and result
    logic [1:0]                 r_mode;
    logic [evid_pkg::NUM_W-1:0] r_number;
    logic [evid_pkg::TAG_W-1:0] r_cb;
    logic [evid_pkg::TAG_W-1:0] r_arg;
    logic [SW-1:0]              r_span;
    logic [1:0]                 r_res_status;
    logic [evid_pkg::NUM_W-1:0] r_res_granted;
    logic [evid_pkg::TAG_W-1:0] r_res_cb;
    logic [evid_pkg::TAG_W-1:0] r_res_arg;
    logic [1:0]                 r_out_status;
    logic [evid_pkg::NUM_W-1:0] r_out_granted;
    logic [evid_pkg::TAG_W-1:0] r_out_cb;
    logic [evid_pkg::TAG_W-1:0] r_out_arg;
    logic [evid_pkg::PEAK_W-1:0] r_out_peak;

    logic [16:0]   w_diff;
    logic [16:0]   w_cnt;
    logic [SW-1:0] w_span;
    logic [16:0]   w_ndiff;
    logic [SW-1:0] w_live_inc;
    logic [DW-1:0] w_dec;

    logic          w_tk_we;
    logic          w_dp_we;
    logic [BW-1:0] w_dp_addr;
    logic [DW-1:0] w_dp_wd;

    // managed span from the range registers
    always_comb begin
        w_diff = {1'b0, r_last} - {1'b0, r_first};
        w_cnt  = w_diff + 17'd1;
        if (r_last < r_first) begin
            w_span = '0;
        end else if (w_cnt > 17'(ID_SPACE)) begin
            w_span = SW'(ID_SPACE);
        end else begin
            w_span = SW'(w_cnt);
        end
    end

    assign w_ndiff    = {1'b0, r_number} - {1'b0, r_first};
    assign w_live_inc = r_live + SW'(1);
    assign w_dec      = r_depth_q - DW'(1);

    // flags for the controller
    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.none         = r_none;
        o_stat.in_range     = (r_number >= r_first) && (32'(w_ndiff) < 32'(r_span));
        o_stat.off_lt_span  = 32'(r_off) < 32'(r_span);
        o_stat.taken        = r_taken_q;
        o_stat.short_span   = 32'(r_span) <= BIN_COUNT;
        o_stat.scan_lt_span = 32'(r_daddr) < 32'(r_span);
        o_stat.scan_end     = 32'(r_daddr) == BIN_COUNT;
        o_stat.depth_zero   = r_depth_q == '0;
        o_stat.depth_le_min = r_depth_q <= r_min;
        o_stat.rem_ge_bc    = 32'(r_off) >= BIN_COUNT;
        o_stat.clr_done     = 32'(r_off) == CLR_LEN - 1;
    end

    // memory write controls
    always_comb begin
        w_tk_we   = ((i_op == evid_pkg::OP_CLEAR) && (32'(r_off) < ID_SPACE))
                    || (i_op == evid_pkg::OP_GRANT) || (i_op == evid_pkg::OP_FREE);
        w_dp_we   = 1'b0;
        w_dp_addr = r_bin;
        w_dp_wd   = '0;
        case (i_op)
            evid_pkg::OP_CLEAR: begin
                w_dp_we   = 32'(r_off) < BIN_COUNT;
                w_dp_addr = r_off[BW-1:0];
            end
            evid_pkg::OP_INC: begin
                w_dp_we = 1'b1;
                w_dp_wd = r_depth_q + DW'(1);
            end
            evid_pkg::OP_DEC: begin
                w_dp_we = 1'b1;
                w_dp_wd = w_dec;
            end
            default: begin
                w_dp_we = 1'b0;
            end
        endcase
    end

    // memories: registered reads, single write port each
    always_ff @(posedge i_clk) begin
        r_taken_q <= r_taken_mem[r_off[OW-1:0]];
        r_hdl_q   <= r_hdl_mem[r_off[OW-1:0]];
        r_depth_q <= r_depth_mem[r_daddr[BW-1:0]];
        if (w_tk_we) begin
            r_taken_mem[r_off[OW-1:0]] <= (i_op == evid_pkg::OP_GRANT);
        end
        if (i_op == evid_pkg::OP_GRANT) begin
            r_hdl_mem[r_off[OW-1:0]] <= {r_cb, r_arg};
        end
        if (w_dp_we) begin
            r_depth_mem[w_dp_addr] <= w_dp_wd;
        end
    end

    // allocator control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= evid_pkg::FIRST_RST;
            r_last   <= evid_pkg::LAST_RST;
            r_off    <= '0;
            r_daddr  <= '0;
            r_bin    <= '0;
            r_next   <= '0;
            r_none   <= 1'b0;
            r_min    <= '0;
            r_live   <= '0;
            r_peak   <= '0;
            r_found  <= 1'b0;
            r_best   <= '0;
            r_best_d <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == evid_pkg::REG_FIRST) begin
                    r_first <= i_cfg_wdata;
                end else begin
                    r_last <= i_cfg_wdata;
                end
            end
            case (i_op)
                evid_pkg::OP_CLR_INIT: begin
                    r_off  <= '0;
                    r_next <= '0;
                    r_none <= 1'b0;
                    r_min  <= '0;
                    r_live <= '0;
                    r_peak <= '0;
                end
                evid_pkg::OP_CLEAR:       r_off <= r_off + OFW'(1);
                evid_pkg::OP_ALLOC_START: begin
                    r_off <= OFW'(r_next);
                    r_bin <= r_next;
                end
                evid_pkg::OP_OFF_STEP:    r_off <= r_off + OFW'(BIN_COUNT);
                evid_pkg::OP_SET_NONE:    r_none <= 1'b1;
                evid_pkg::OP_GRANT: begin
                    r_live  <= w_live_inc;
                    if (w_live_inc > r_peak) begin
                        r_peak <= w_live_inc;
                    end
                    r_daddr <= DAW'(r_bin);
                end
                evid_pkg::OP_ADV_START: begin
                    if (o_stat.short_span) begin
                        r_none  <= 1'b1;
                        r_daddr <= DAW'(r_bin) + DAW'(1);
                    end else if (32'(r_bin) == BIN_COUNT - 1) begin
                        r_daddr <= '0;
                    end else begin
                        r_daddr <= DAW'(r_bin) + DAW'(1);
                    end
                end
                evid_pkg::OP_SCAN_STEP:   r_daddr <= r_daddr + DAW'(1);
                evid_pkg::OP_SET_NEXT: begin
                    r_next <= r_daddr[BW-1:0];
                    r_none <= 1'b0;
                end
                evid_pkg::OP_P2_START: begin
                    r_daddr <= '0;
                    r_found <= 1'b0;
                end
                evid_pkg::OP_P2_ACC: begin
                    if ((r_depth_q > r_min) && (!r_found || (r_depth_q < r_best_d))) begin
                        r_found  <= 1'b1;
                        r_best   <= r_daddr[BW-1:0];
                        r_best_d <= r_depth_q;
                    end
                    r_daddr <= r_daddr + DAW'(1);
                end
                evid_pkg::OP_P2_END: begin
                    if (r_found) begin
                        r_min  <= r_best_d;
                        r_next <= r_best;
                    end else begin
                        r_none <= 1'b1;
                    end
                end
                evid_pkg::OP_SET_OFF:     r_off <= OFW'(w_ndiff);
                evid_pkg::OP_FREE:        r_live <= r_live - SW'(1);
                evid_pkg::OP_MOD_STEP:    r_off <= r_off - OFW'(BIN_COUNT);
                evid_pkg::OP_MOD_DONE: begin
                    r_bin   <= r_off[BW-1:0];
                    r_daddr <= DAW'(r_off);
                end
                evid_pkg::OP_DEC: begin
                    // freed bin is pointer below the min; at it, if lower or none set
                    if (w_dec == r_min) begin
                        if (r_none || (r_bin < r_next)) begin
                            r_next <= r_bin;
                            r_none <= 1'b0;
                        end
                    end else if (w_dec < r_min) begin
                        r_min  <= w_dec;
                        r_next <= r_bin;
                        r_none <= 1'b0;
                    end
                end
                default: begin
                    r_none <= r_none;
                end
            endcase
        end
    end

    // request latch, result build and output register
    always_ff @(posedge i_clk) begin
        case (i_op)
            evid_pkg::OP_LOAD: begin
                r_mode        <= i_mode;
                r_number      <= i_number;
                r_cb          <= i_cb;
                r_arg         <= i_arg;
                r_span        <= w_span;
                r_res_status  <= evid_pkg::STS_FAIL;
                r_res_granted <= (i_mode == evid_pkg::MODE_ALLOC) ? '0 : i_number;
                r_res_cb      <= '0;
                r_res_arg     <= '0;
            end
            evid_pkg::OP_SET_RANGE: r_res_status <= evid_pkg::STS_RANGE;
            evid_pkg::OP_GRANT: begin
                r_res_status  <= evid_pkg::STS_OK;
                r_res_granted <= r_first + 16'(r_off);
            end
            evid_pkg::OP_DISPATCH: begin
                r_res_status <= evid_pkg::STS_OK;
                r_res_cb     <= r_hdl_q[2*evid_pkg::TAG_W-1:evid_pkg::TAG_W];
                r_res_arg    <= r_hdl_q[evid_pkg::TAG_W-1:0];
            end
            evid_pkg::OP_FREE:      r_res_status <= evid_pkg::STS_OK;
            evid_pkg::OP_EMIT: begin
                r_out_status  <= r_res_status;
                r_out_granted <= r_res_granted;
                r_out_cb      <= r_res_cb;
                r_out_arg     <= r_res_arg;
                r_out_peak    <= evid_pkg::PEAK_W'(r_peak);
            end
            default: begin
                r_mode <= r_mode;
            end
        endcase
    end

    assign o_status  = r_out_status;
    assign o_granted = r_out_granted;
    assign o_cb      = r_out_cb;
    assign o_arg     = r_out_arg;
    assign o_peak    = r_out_peak;

endmodule
`default_nettype wire

### design/evid_ctrl.sv
// Sequencer of the event number allocator: steps the datapath through
// clearing, allocation walk, bin scans, dispatch lookup and free. Uses evid_pkg.
`default_nettype none
module evid_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_s_valid,
    input  wire logic                i_m_ready,
    input  wire evid_pkg::t_dp_stat  i_stat,
    output evid_pkg::t_dp_op         o_op,
    output logic                     o_s_ready,
    output logic                     o_m_valid
);

    evid_pkg::t_state r_state;
    evid_pkg::t_state n_state;
    logic             r_m_valid;
    logic             w_emit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            evid_pkg::ST_CLEAR:     if (i_stat.clr_done) n_state = evid_pkg::ST_IDLE;
            evid_pkg::ST_IDLE:      if (i_s_valid) n_state = evid_pkg::ST_DECODE;
            evid_pkg::ST_DECODE: begin
                if (i_stat.mode == evid_pkg::MODE_ALLOC) begin
                    n_state = i_stat.none ? evid_pkg::ST_FINISH : evid_pkg::ST_WALK_WAIT;
                end else if ((i_stat.mode == evid_pkg::MODE_DISPATCH)
                             || (i_stat.mode == evid_pkg::MODE_FREE)) begin
                    n_state = i_stat.in_range ? evid_pkg::ST_TK_WAIT : evid_pkg::ST_FINISH;
                end else begin
                    n_state = evid_pkg::ST_FINISH;
                end
            end
            evid_pkg::ST_WALK_WAIT: n_state = evid_pkg::ST_WALK_CHK;
            evid_pkg::ST_WALK_CHK: begin
                if (!i_stat.off_lt_span) n_state = evid_pkg::ST_FINISH;
                else if (i_stat.taken)   n_state = evid_pkg::ST_WALK_WAIT;
                else                     n_state = evid_pkg::ST_INC_WAIT;
            end
            evid_pkg::ST_INC_WAIT:  n_state = evid_pkg::ST_INC;
            evid_pkg::ST_INC:       n_state = evid_pkg::ST_ADV;
            evid_pkg::ST_ADV:
                n_state = i_stat.short_span ? evid_pkg::ST_SM_WAIT : evid_pkg::ST_P1_WAIT;
            evid_pkg::ST_SM_WAIT:   n_state = evid_pkg::ST_SM_CHK;
            evid_pkg::ST_SM_CHK: begin
                if (!i_stat.scan_lt_span || i_stat.depth_zero) n_state = evid_pkg::ST_FINISH;
                else                                           n_state = evid_pkg::ST_SM_WAIT;
            end
            evid_pkg::ST_P1_WAIT:   n_state = evid_pkg::ST_P1_CHK;
            evid_pkg::ST_P1_CHK: begin
                if (i_stat.scan_end)          n_state = evid_pkg::ST_P2_WAIT;
                else if (i_stat.depth_le_min) n_state = evid_pkg::ST_FINISH;
                else                          n_state = evid_pkg::ST_P1_WAIT;
            end
            evid_pkg::ST_P2_WAIT:   n_state = evid_pkg::ST_P2_CHK;
            evid_pkg::ST_P2_CHK:
                n_state = i_stat.scan_end ? evid_pkg::ST_FINISH : evid_pkg::ST_P2_WAIT;
            evid_pkg::ST_TK_WAIT:   n_state = evid_pkg::ST_TK_CHK;
            evid_pkg::ST_TK_CHK: begin
                if (i_stat.taken && (i_stat.mode == evid_pkg::MODE_FREE)) begin
                    n_state = evid_pkg::ST_MOD;
                end else begin
                    n_state = evid_pkg::ST_FINISH;
                end
            end
            evid_pkg::ST_MOD:       if (!i_stat.rem_ge_bc) n_state = evid_pkg::ST_DEC_WAIT;
            evid_pkg::ST_DEC_WAIT:  n_state = evid_pkg::ST_DEC;
            evid_pkg::ST_DEC:       n_state = evid_pkg::ST_FINISH;
            evid_pkg::ST_FINISH:    if (!r_m_valid || i_m_ready) n_state = evid_pkg::ST_IDLE;
            default:                n_state = evid_pkg::ST_CLEAR;
        endcase
        // a register write restarts the clearing sweep
        if (i_cfg_we) n_state = evid_pkg::ST_CLEAR;
    end

    // datapath command
    always_comb begin
        o_op = evid_pkg::OP_NONE;
        unique case (r_state)
            evid_pkg::ST_CLEAR:     o_op = evid_pkg::OP_CLEAR;
            evid_pkg::ST_IDLE:      if (i_s_valid) o_op = evid_pkg::OP_LOAD;
            evid_pkg::ST_DECODE: begin
                if (i_stat.mode == evid_pkg::MODE_ALLOC) begin
                    if (!i_stat.none) o_op = evid_pkg::OP_ALLOC_START;
                end else if ((i_stat.mode == evid_pkg::MODE_DISPATCH)
                             || (i_stat.mode == evid_pkg::MODE_FREE)) begin
                    o_op = i_stat.in_range ? evid_pkg::OP_SET_OFF : evid_pkg::OP_SET_RANGE;
                end
            end
            evid_pkg::ST_WALK_CHK: begin
                if (!i_stat.off_lt_span) o_op = evid_pkg::OP_SET_NONE;
                else if (i_stat.taken)   o_op = evid_pkg::OP_OFF_STEP;
                else                     o_op = evid_pkg::OP_GRANT;
            end
            evid_pkg::ST_INC:       o_op = evid_pkg::OP_INC;
            evid_pkg::ST_ADV:       o_op = evid_pkg::OP_ADV_START;
            evid_pkg::ST_SM_CHK: begin
                if (i_stat.scan_lt_span) begin
                    o_op = i_stat.depth_zero ? evid_pkg::OP_SET_NEXT : evid_pkg::OP_SCAN_STEP;
                end
            end
            evid_pkg::ST_P1_CHK: begin
                if (i_stat.scan_end)          o_op = evid_pkg::OP_P2_START;
                else if (i_stat.depth_le_min) o_op = evid_pkg::OP_SET_NEXT;
                else                          o_op = evid_pkg::OP_SCAN_STEP;
            end
            evid_pkg::ST_P2_CHK:
                o_op = i_stat.scan_end ? evid_pkg::OP_P2_END : evid_pkg::OP_P2_ACC;
            evid_pkg::ST_TK_CHK: begin
                if (i_stat.taken) begin
                    o_op = (i_stat.mode == evid_pkg::MODE_FREE) ? evid_pkg::OP_FREE
                                                                : evid_pkg::OP_DISPATCH;
                end
            end
            evid_pkg::ST_MOD:
                o_op = i_stat.rem_ge_bc ? evid_pkg::OP_MOD_STEP : evid_pkg::OP_MOD_DONE;
            evid_pkg::ST_DEC:       o_op = evid_pkg::OP_DEC;
            evid_pkg::ST_FINISH:    if (!r_m_valid || i_m_ready) o_op = evid_pkg::OP_EMIT;
            default:                o_op = evid_pkg::OP_NONE;
        endcase
        if (i_cfg_we) o_op = evid_pkg::OP_CLR_INIT;
    end

    assign w_emit    = (o_op == evid_pkg::OP_EMIT);
    assign o_s_ready = (r_state == evid_pkg::ST_IDLE) && !i_cfg_we;
    assign o_m_valid = r_m_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= evid_pkg::ST_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### design/event_id_allocator_top.sv
// Event number allocator: one request at a time, next item taken in the cycle after the
// result is registered. Dispatch reads the taken map and handler store; free clears the
// taken bit, reduces the offset modulo BIN_COUNT and decrements the bin depth; allocate
// walks its bin's chain in the taken map, then scans bin depths (up to two passes when the
// span exceeds BIN_COUNT), all through the single read port of the taken and depth memories.
// A stalled result holds the block. Reset or a register write clears taken bits and depths.
`default_nettype none
module event_id_allocator_top #(
    parameter int BIN_COUNT = evid_pkg::BIN_COUNT_DEF,
    parameter int ID_SPACE  = evid_pkg::ID_SPACE_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [79:0]  s_axis_tdata,   // event_number, callback_tag, argument_tag
    input  wire logic [1:0]   s_axis_tuser,   // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // granted_number, found_callback,
                                              // found_argument, peak_allocated
    output logic [1:0]        m_axis_tuser    // status
);

    evid_pkg::t_dp_op   w_op;
    evid_pkg::t_dp_stat w_stat;
    logic [evid_pkg::NUM_W-1:0]  w_granted;
    logic [evid_pkg::TAG_W-1:0]  w_cb;
    logic [evid_pkg::TAG_W-1:0]  w_arg;
    logic [evid_pkg::PEAK_W-1:0] w_peak;

    evid_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_op      (w_op),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    evid_dp #(
        .BIN_COUNT (BIN_COUNT),
        .ID_SPACE  (ID_SPACE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (s_axis_tuser),
        .i_number    (s_axis_tdata[15:0]),
        .i_cb        (s_axis_tdata[47:16]),
        .i_arg       (s_axis_tdata[79:48]),
        .o_stat      (w_stat),
        .o_status    (m_axis_tuser),
        .o_granted   (w_granted),
        .o_cb        (w_cb),
        .o_arg       (w_arg),
        .o_peak      (w_peak)
    );

    assign m_axis_tdata = {2'b00, w_peak, w_arg, w_cb, w_granted};

    // a register write always starts a clearing sweep
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("input ready right after a register write");

    // one request in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    // a result only appears from the finishing step of a request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result raised while the block was idle");

endmodule
`default_nettype wire

### tb/tb_event_id_allocator_top.sv
// Self-checking testbench for event_id_allocator_top: directed table, then random traffic.
// Predicts results from the typed table rows or a local allocator model; depends on evid_pkg and the top level.
`default_nettype none
module tb_event_id_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int BINS = 256;
    localparam int SPACE = 8192;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] number;
        logic [31:0] cb;
        logic [31:0] arg;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted;
        logic [31:0] cb;
        logic [31:0] arg;
        logic [13:0] peak;
    } t_resp;

    typedef struct packed {
        t_req  rq;
        logic  typed;
        t_resp rs;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // event_number, callback_tag, argument_tag
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // granted_number, found_callback, found_argument, peak
    logic [1:0]  m_axis_tuser;        // status

    event_id_allocator_top dut (.*);

    always #4 i_clk = ~i_clk;

    // allocator mirror
    logic        taken[SPACE];
    logic [63:0] tags[SPACE];
    int unsigned bin_fill[BINS];
    int unsigned next_bin, min_fill, live_cnt, peak_cnt;
    bit          no_bin;
    int unsigned first_ev = 16'h2000, last_ev = 16'h4000;

    t_resp       pending[$];
    logic [15:0] granted_log[$];
    int          errors = 0;
    int          checked = 0;
    int          idle_pct = 27;

    function automatic void clear_mirror();
        for (int i = 0; i < SPACE; i++) begin
            taken[i] = 1'b0;
            tags[i] = '0;
        end
        for (int i = 0; i < BINS; i++) bin_fill[i] = 0;
        next_bin = 0; no_bin = 0; min_fill = 0; live_cnt = 0; peak_cnt = 0;
    endfunction

    function automatic int unsigned span_size();
        int unsigned n;
        if (last_ev < first_ev) return 0;
        n = last_ev - first_ev + 1;
        return (n > SPACE) ? SPACE : n;
    endfunction

    // after a grant, move the pointer to the next bin at or below min_fill, else (long span) the shallowest
    function automatic void move_pointer(int unsigned bin, int unsigned n);
        int unsigned best = 0, best_fill = 0;
        bit found = 0;
        if (n <= BINS) begin
            no_bin = 1;
            for (int unsigned i = bin + 1; i < n; i++)
                if (bin_fill[i] == 0) begin
                    next_bin = i; no_bin = 0;
                    return;
                end
            return;
        end
        for (int unsigned i = (bin + 1) % BINS; i < BINS; i++)
            if (bin_fill[i] <= min_fill) begin
                next_bin = i;
                return;
            end
        for (int unsigned i = 0; i < BINS; i++)
            if (bin_fill[i] > min_fill && (!found || bin_fill[i] < best_fill)) begin
                found = 1; best = i; best_fill = bin_fill[i];
            end
        if (found) begin
            min_fill = best_fill; next_bin = best;
        end else begin
            no_bin = 1;
        end
    endfunction

    function automatic t_resp allocate_or_lookup(t_req rq);
        t_resp rs;
        int unsigned n, off, bin, d;
        n = span_size();
        rs = '0;
        rs.status = evid_pkg::STS_FAIL;
        rs.granted = rq.number;
        if (rq.mode == evid_pkg::MODE_ALLOC) begin
            rs.granted = '0;
            if (!no_bin) begin
                bin = next_bin;
                for (off = bin; off < n; off += BINS)
                    if (!taken[off]) break;
                if (off >= n) begin
                    no_bin = 1;
                end else begin
                    taken[off] = 1'b1;
                    tags[off] = {rq.cb, rq.arg};
                    bin_fill[bin]++;
                    live_cnt++;
                    if (live_cnt > peak_cnt) peak_cnt = live_cnt;
                    rs.status = evid_pkg::STS_OK;
                    rs.granted = 16'(first_ev + off);
                    granted_log.push_back(rs.granted);
                    move_pointer(bin, n);
                end
            end
        end else if (rq.mode == evid_pkg::MODE_DISPATCH || rq.mode == evid_pkg::MODE_FREE) begin
            if (rq.number < first_ev || rq.number - first_ev >= n) begin
                rs.status = evid_pkg::STS_RANGE;
            end else begin
                off = rq.number - first_ev;
                if (taken[off]) begin
                    rs.status = evid_pkg::STS_OK;
                    if (rq.mode == evid_pkg::MODE_DISPATCH) begin
                        {rs.cb, rs.arg} = tags[off];
                    end else begin
                        taken[off] = 1'b0;
                        bin = off % BINS;
                        d = --bin_fill[bin];
                        if (d == min_fill) begin
                            if (no_bin || bin < next_bin) begin
                                next_bin = bin; no_bin = 0;
                            end
                        end else if (d < min_fill) begin
                            min_fill = d; next_bin = bin; no_bin = 0;
                        end
                        live_cnt--;
                    end
                end
            end
        end
        rs.peak = 14'(peak_cnt);
        return rs;
    endfunction

    // send one item; valid stays high into the next item unless an idle cycle follows
    task automatic send_item(t_req rq, bit typed, t_resp typed_rs);
        t_resp rs;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rq.arg, rq.cb, rq.number};
        s_axis_tuser <= rq.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        rs = allocate_or_lookup(rq);
        pending.push_back(typed ? typed_rs : rs);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        wait (pending.size() == 0);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == evid_pkg::REG_FIRST) first_ev = 32'(val); else last_ev = 32'(val);
        clear_mirror();
        granted_log.delete();
    endtask

    function automatic t_req random_req();
        t_req rq;
        int unsigned pick, n;
        n = span_size();
        pick = $urandom_range(99);
        rq.cb = $urandom;
        rq.arg = $urandom;
        rq.mode = (pick < 45) ? evid_pkg::MODE_ALLOC : (pick < 70) ? evid_pkg::MODE_DISPATCH :
                  (pick < 96) ? evid_pkg::MODE_FREE : MODE_UNUSED;
        pick = $urandom_range(99);
        if (pick < 65 && granted_log.size() > 0)
            rq.number = granted_log[$urandom_range(granted_log.size() - 1)];
        else if (pick < 85 && n > 0)
            rq.number = 16'(first_ev + $urandom_range(n - 1));
        else
            rq.number = 16'($urandom);
        return rq;
    endfunction

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        t_resp got, want;
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
                   m_axis_tdata[79:48], m_axis_tdata[93:80]};
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending.pop_front();
                if (got !== want || m_axis_tdata[95:94] !== 2'b00) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp sts %0d num %h cb %h arg %h peak %0d",
                                  " | got sts %0d num %h cb %h arg %h peak %0d"},
                                 want.status, want.granted, want.cb, want.arg, want.peak,
                                 got.status, got.granted, got.cb, got.arg, got.peak);
                end
            end
        end
    end

    t_row rows[14] = '{
        '{'{evid_pkg::MODE_ALLOC, 16'h0000, 32'hA5A5_0001, 32'h5A5A_0002}, 1'b1,
          '{evid_pkg::STS_OK, 16'h2000, 32'h0, 32'h0, 14'd1}},
        '{'{evid_pkg::MODE_DISPATCH, 16'h2000, 32'h0, 32'h0}, 1'b1,
          '{evid_pkg::STS_OK, 16'h2000, 32'hA5A5_0001, 32'h5A5A_0002, 14'd1}},
        '{'{evid_pkg::MODE_DISPATCH, 16'h1FFF, 32'h0, 32'h0}, 1'b1,
          '{evid_pkg::STS_RANGE, 16'h1FFF, 32'h0, 32'h0, 14'd1}},
        '{'{evid_pkg::MODE_FREE, 16'h4001, 32'h0, 32'h0}, 1'b1,
          '{evid_pkg::STS_RANGE, 16'h4001, 32'h0, 32'h0, 14'd1}},
        '{'{evid_pkg::MODE_DISPATCH, 16'h2001, 32'h0, 32'h0}, 1'b1,
          '{evid_pkg::STS_FAIL, 16'h2001, 32'h0, 32'h0, 14'd1}},
        '{'{MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{evid_pkg::STS_FAIL, 16'hFFFF, 32'h0, 32'h0, 14'd1}},
        '{'{evid_pkg::MODE_DISPATCH, 16'h0000, 32'h0, 32'h0}, 1'b1,
          '{evid_pkg::STS_RANGE, 16'h0000, 32'h0, 32'h0, 14'd1}},
        '{'{evid_pkg::MODE_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{evid_pkg::MODE_DISPATCH, 16'h2001, 32'h0, 32'h0}, 1'b0, '0},
        '{'{evid_pkg::MODE_FREE, 16'h2000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{evid_pkg::MODE_FREE, 16'h2000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{evid_pkg::MODE_ALLOC, 16'h0000, 32'h0, 32'h0}, 1'b0, '0},
        '{'{evid_pkg::MODE_DISPATCH, 16'hFFFF, 32'h0, 32'h0}, 1'b0, '0},
        '{'{evid_pkg::MODE_FREE, 16'h4000, 32'h0, 32'h0}, 1'b0, '0}
    };

    // settings per random phase: first, last, item count
    int unsigned phase_first[7] = '{16'h2000, 16'd1000, 16'd5000, 16'd0, 16'hFFDC,
                                    16'hFFFF, 16'd300};
    int unsigned phase_last[7]  = '{16'h4000, 16'd1299, 16'd5039, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'd200};
    int          phase_items[7] = '{250, 500, 450, 150, 200, 120, 100};

    initial begin
        clear_mirror();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) send_item(rows[r].rq, rows[r].typed, rows[r].rs);

        for (int p = 0; p < 7; p++) begin
            write_reg(evid_pkg::REG_FIRST, 16'(phase_first[p]));
            write_reg(evid_pkg::REG_LAST, 16'(phase_last[p]));
            for (int k = 0; k < phase_items[p]; k++) begin
                // a stretch without any idling in the middle of the second phase
                idle_pct = (p == 1 && k >= 150 && k < 300) ? 0 : 27;
                send_item(random_req(), 1'b0, '0);
            end
        end
        idle_pct = 27;
        s_axis_tvalid <= 1'b0;
        wait (pending.size() == 0);
        repeat (600) @(posedge i_clk);
        $display("Ran %0d results over 7 range settings: allocate, dispatch, free, unused mode,",
                 checked);
        $display("exhaustion, out-of-range and empty span cases; %0d mismatches", errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
design/evid_pkg.sv
design/evid_dp.sv
design/evid_ctrl.sv
design/event_id_allocator_top.sv
tb/tb_event_id_allocator_top.sv
